[sv/checksum_packet_sync_top_assert.svh]
// Assertion macros for the checksum packet sync block
`ifndef CHECKSUM_PACKET_SYNC_TOP_ASSERT_SVH
`define CHECKSUM_PACKET_SYNC_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("checksum_packet_sync: implication check failed");
`define CPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("checksum_packet_sync: next-cycle check failed");
`else
`define CPS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CPS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

[sv/cps_pkg.sv]
// Shared types and constants for the checksum packet sync block
`default_nettype none

package cps_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned WORD_W    = 32;
  localparam int unsigned OUT_WORDS = 5;

  // running sum and sum of running sums travelling down the cell chain
  typedef struct packed {
    logic [WORD_W-1:0] run;
    logic [WORD_W-1:0] tot;
  } sums_t;

endpackage

`default_nettype wire

[sv/cps_cell.sv]
// One accumulation cell: folds data word K into the running sums
`default_nettype none

module cps_cell #(
  parameter int unsigned WORDS_PER_PACKET = 6,
  parameter int unsigned K                = 0
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          en_i,
  input  wire logic                                          valid_i,
  input  wire cps_pkg::sums_t                                sums_i,
  input  wire logic [WORDS_PER_PACKET-1:0][cps_pkg::WORD_W-1:0] win_i,
  output logic                                               valid_o,
  output cps_pkg::sums_t                                     sums_o,
  output logic [WORDS_PER_PACKET-1:0][cps_pkg::WORD_W-1:0]   win_o
);

  logic                                                    valid_q;
  cps_pkg::sums_t                                          sums_q, sums_d;
  logic [WORDS_PER_PACKET-1:0][cps_pkg::WORD_W-1:0]        win_q;

  // total lags run by one cell; the check stage adds the last run
  always_comb begin
    sums_d.run = sums_i.run + win_i[K];
    sums_d.tot = sums_i.tot + sums_i.run;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sums_q <= sums_d;
      win_q  <= win_i;
    end
  end

  assign valid_o = valid_q;
  assign sums_o  = sums_q;
  assign win_o   = win_q;

endmodule

`default_nettype wire

[sv/cps_check.sv]
// Final check stage: compare, refill tracking and result register
`default_nettype none

module cps_check #(
  parameter int unsigned WORDS_PER_PACKET = 6
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          rst_ni,
  input  wire logic                                          valid_i,
  input  wire cps_pkg::sums_t                                sums_i,
  input  wire logic [WORDS_PER_PACKET-1:0][cps_pkg::WORD_W-1:0] win_i,
  input  wire logic                                          out_stall_i,
  output logic                                               en_o,
  output logic                                               out_valid_o,
  output logic [cps_pkg::OUT_WORDS-1:0][cps_pkg::WORD_W-1:0] words_o
);

  localparam int unsigned WIN_BYTES = WORDS_PER_PACKET * 4;
  localparam int unsigned FILL_W    = $clog2(WIN_BYTES + 1);
  localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(WIN_BYTES);

  logic                                                    out_valid_q;
  logic [cps_pkg::OUT_WORDS-1:0][cps_pkg::WORD_W-1:0]      words_q, words_d;
  logic [FILL_W-1:0]                                       fill_q, fill_d, fill_inc;
  logic [cps_pkg::WORD_W-1:0]                              chk;
  logic                                                    hit;
  logic                                                    en;

  // whole chain moves unless a finished result is held back
  assign en = !out_valid_q || !out_stall_i;

  always_comb begin
    fill_inc = (fill_q == FILL_MAX) ? FILL_MAX : fill_q + FILL_W'(1);
    chk      = sums_i.tot + sums_i.run;
    hit      = valid_i && (fill_inc == FILL_MAX) && (chk == win_i[WORDS_PER_PACKET-1]);
    fill_d   = hit ? '0 : fill_inc;
  end

  // data words beyond the packet read as zero
  for (genvar j = 0; j < cps_pkg::OUT_WORDS; j++) begin : g_out
    if (j < WORDS_PER_PACKET - 1) begin : g_data
      assign words_d[j] = win_i[j];
    end else begin : g_zero
      assign words_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      fill_q      <= '0;
    end else if (en) begin
      out_valid_q <= hit;
      if (valid_i) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && hit) begin
      words_q <= words_d;
    end
  end

  assign en_o        = en;
  assign out_valid_o = out_valid_q;
  assign words_o     = words_q;

endmodule

`default_nettype wire

[sv/checksum_packet_sync_top.sv]
// Top level of the checksum packet sync block: byte window and cell chain
// A byte accepted at an edge loads cell 0 with the updated window, then passes through
// each further cell in order and through the check stage into the result register,
// from which it transfers out when the receiver does not stall.
// Throughput: one byte per cycle; the chain halts only while a result is stalled.
// Reset (rst_ni low, asynchronous): window cleared, refill count zero, chain emptied.
`default_nettype none

`include "checksum_packet_sync_top_assert.svh"

module checksum_packet_sync_top #(
  parameter int unsigned WORDS_PER_PACKET = 6
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  // byte input channel
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [cps_pkg::BYTE_W-1:0]  in_byte_i,
  // packet output channel
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [cps_pkg::WORD_W-1:0]       word_0_o,
  output logic [cps_pkg::WORD_W-1:0]       word_1_o,
  output logic [cps_pkg::WORD_W-1:0]       word_2_o,
  output logic [cps_pkg::WORD_W-1:0]       word_3_o,
  output logic [cps_pkg::WORD_W-1:0]       word_4_o
);

  localparam int unsigned WIN_BYTES = WORDS_PER_PACKET * 4;

  // sliding byte window, element 0 is the oldest byte
  logic [WIN_BYTES-1:0][cps_pkg::BYTE_W-1:0]               win_q, win_d;
  logic                                                    in_xfer;
  logic                                                    en;

  // chain taps: index k feeds cell k, the last index feeds the check stage
  logic                                                    vld_c  [WORDS_PER_PACKET];
  cps_pkg::sums_t                                          sums_c [WORDS_PER_PACKET];
  logic [WORDS_PER_PACKET-1:0][cps_pkg::WORD_W-1:0]        win_c  [WORDS_PER_PACKET];

  logic [cps_pkg::OUT_WORDS-1:0][cps_pkg::WORD_W-1:0]      words;

  assign in_stall_o = !en;
  assign in_xfer    = in_valid_i && en;

  // new byte enters at the top; the packed window reads directly as
  // little-endian words since byte 4k is the low byte of word k
  assign win_d = {in_byte_i, win_q[WIN_BYTES-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q <= '0;
    end else if (in_xfer) begin
      win_q <= win_d;
    end
  end

  // head of the chain: snapshot of the window after this byte
  assign vld_c[0]  = in_valid_i;
  assign sums_c[0] = '0;
  assign win_c[0]  = win_d;

  // one cell per data word; cell k adds word k to the running sum
  for (genvar k = 0; k < WORDS_PER_PACKET - 1; k++) begin : g_cell
    cps_cell #(
      .WORDS_PER_PACKET (WORDS_PER_PACKET),
      .K                (k)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (vld_c[k]),
      .sums_i  (sums_c[k]),
      .win_i   (win_c[k]),
      .valid_o (vld_c[k+1]),
      .sums_o  (sums_c[k+1]),
      .win_o   (win_c[k+1])
    );
  end

  // completes the check value, tracks refill and holds the result
  cps_check #(
    .WORDS_PER_PACKET (WORDS_PER_PACKET)
  ) u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld_c[WORDS_PER_PACKET-1]),
    .sums_i      (sums_c[WORDS_PER_PACKET-1]),
    .win_i       (win_c[WORDS_PER_PACKET-1]),
    .out_stall_i (out_stall_i),
    .en_o        (en),
    .out_valid_o (out_valid_o),
    .words_o     (words)
  );

  assign word_0_o = words[0];
  assign word_1_o = words[1];
  assign word_2_o = words[2];
  assign word_3_o = words[3];
  assign word_4_o = words[4];

  // input is held off only by a result that waits
  `CPS_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // an accepted byte is in the first cell in the next cycle
  `CPS_ASSERT_NXT(a_head_load, clk_i, rst_ni, in_valid_i && !in_stall_o, vld_c[1])
  // a new result only comes from an item leaving the last cell
  `CPS_ASSERT_IMP(a_result_src, clk_i, rst_ni, $rose(out_valid_o), $past(vld_c[WORDS_PER_PACKET-1]))

endmodule

`default_nettype wire

[test/checksum_packet_sync_top_tb.sv]
`timescale 1ns / 100ps
// Testbench for checksum_packet_sync_top: byte stream in, checked packets out
module checksum_packet_sync_top_tb;

  localparam int unsigned WPP          = 6;
  localparam int unsigned WIN_BYTES    = WPP * 4;
  localparam int unsigned LONG_HOLD    = 300;
  localparam int unsigned RANDOM_BYTES = 660;
  localparam int          NO_FLIP      = -1;

  typedef logic [cps_pkg::WORD_W-1:0]                         word_t;
  typedef logic [WPP-2:0][cps_pkg::WORD_W-1:0]                data_words_t;
  typedef logic [cps_pkg::OUT_WORDS-1:0][cps_pkg::WORD_W-1:0] out_words_t;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_HEAVY} stall_mode_e;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_stall_o;
  logic [cps_pkg::BYTE_W-1:0] in_byte_i;
  logic                       out_valid_o;
  logic                       out_stall_i;
  word_t                      word_0_o, word_1_o, word_2_o, word_3_o, word_4_o;

  // predictor state: sliding byte window and refill count
  logic [cps_pkg::BYTE_W-1:0] window_q [WIN_BYTES];
  int unsigned                refill_cnt;
  out_words_t                 packets_due [$];

  int unsigned bytes_sent         = 0;
  int unsigned mismatch_cnt       = 0;
  int unsigned burst_left         = 0;
  int unsigned hold_requests;

  checksum_packet_sync_top #(
    .WORDS_PER_PACKET(WPP)
  ) u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_byte_i   (in_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .word_0_o    (word_0_o),
    .word_1_o    (word_1_o),
    .word_2_o    (word_2_o),
    .word_3_o    (word_3_o),
    .word_4_o    (word_4_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // sum of running sums over the data words, mod 2^32
  function automatic word_t frame_check(input data_words_t d);
    word_t run;
    word_t tot;
    run = '0;
    tot = '0;
    for (int k = 0; k < WPP - 1; k++) begin
      run += d[k];
      tot += run;
    end
    return tot;
  endfunction

  // shift one accepted byte into the window; queue a packet on a match
  task automatic advance_window(input logic [cps_pkg::BYTE_W-1:0] b);
    data_words_t d;
    word_t       last;
    out_words_t  pkt;
    for (int i = 0; i < WIN_BYTES - 1; i++) window_q[i] = window_q[i+1];
    window_q[WIN_BYTES-1] = b;
    if (refill_cnt < WIN_BYTES) refill_cnt++;
    if (refill_cnt == WIN_BYTES) begin
      for (int k = 0; k < WPP - 1; k++)
        d[k] = {window_q[4*k+3], window_q[4*k+2], window_q[4*k+1], window_q[4*k]};
      last = {window_q[WIN_BYTES-1], window_q[WIN_BYTES-2],
              window_q[WIN_BYTES-3], window_q[WIN_BYTES-4]};
      if (frame_check(d) == last) begin
        pkt = '0;
        for (int j = 0; j < cps_pkg::OUT_WORDS; j++)
          if (j < WPP - 1) pkt[j] = d[j];
        packets_due.push_back(pkt);
        refill_cnt = 0;
      end
    end
  endtask

  // one byte transfer; the sender may idle between bursts of random length
  task automatic send_byte(input logic [cps_pkg::BYTE_W-1:0] b);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (in_stall_o);
    advance_window(b);
    bytes_sent++;
    burst_left--;
  endtask

  // first keep bytes of a frame, optionally with one byte corrupted
  task automatic send_frame(input data_words_t d, input int unsigned keep, input int flip_at);
    logic [WPP-1:0][cps_pkg::WORD_W-1:0] frame;
    logic [cps_pkg::BYTE_W-1:0]          b;
    frame = {frame_check(d), d};
    for (int i = 0; i < keep; i++) begin
      b = frame[i/4][8*(i%4) +: 8];
      if (i == flip_at) b ^= 8'($urandom_range(1, 255));
      send_byte(b);
    end
  endtask

  function automatic word_t rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return word_t'(1) << $urandom_range(0, cps_pkg::WORD_W - 1);
      default: return $urandom;
    endcase
  endfunction

  function automatic data_words_t rand_data();
    data_words_t d;
    for (int k = 0; k < WPP - 1; k++) d[k] = rand_word();
    return d;
  endfunction

  function automatic void note_mismatch(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("mismatch at %0t: %s", $time, what);
  endfunction

  // receiver: own stall pattern, plus a long hold-off on request
  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    int unsigned hold_left;
    int unsigned holds_served;
    int unsigned tick;
    mode         = STALL_NONE;
    mode_left    = 50;
    hold_left    = 0;
    holds_served = 0;
    tick         = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_requests != holds_served && hold_left == 0) begin
        hold_left    = LONG_HOLD;
        holds_served = hold_requests;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(20, 150);
        end else begin
          mode_left--;
        end
        case (mode)
          STALL_NONE:     out_stall_i <= 1'b0;
          STALL_RANDOM:   out_stall_i <= ($urandom_range(0, 2) == 0);
          STALL_PERIODIC: out_stall_i <= (tick % 4 == 0);
          default:        out_stall_i <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  // each packet transfer is checked against the oldest expected packet
  always @(posedge clk_i) begin : packet_checker
    out_words_t got;
    out_words_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {word_4_o, word_3_o, word_2_o, word_1_o, word_0_o};
      if (packets_due.size() == 0) begin
        note_mismatch($sformatf("unexpected packet %h", got));
      end else begin
        want = packets_due.pop_front();
        for (int j = 0; j < cps_pkg::OUT_WORDS; j++)
          if (got[j] !== want[j])
            note_mismatch($sformatf("word_%0d: expected %h, got %h", j, want[j], got[j]));
      end
    end
  end

  // all-zero window passes the check; only the byte that completes the refill reports it
  task automatic test_refill_after_reset();
    repeat (WIN_BYTES) send_byte(8'h00);
  endtask

  // saturated words and wrap-around of both sums
  task automatic test_extreme_words();
    data_words_t d;
    d = '1;
    send_frame(d, WIN_BYTES, NO_FLIP);
    for (int k = 0; k < WPP - 1; k++) d[k] = (k % 2 == 0) ? 32'h8000_0001 : 32'hFFFF_FFFF;
    send_frame(d, WIN_BYTES, NO_FLIP);
  endtask

  // receiver holds off while frames keep coming back to back, so the input stalls
  task automatic test_back_pressure();
    hold_requests <= hold_requests + 1;
    burst_left = 1000;
    repeat (3) send_frame(rand_data(), WIN_BYTES, NO_FLIP);
    burst_left = 0;
  endtask

  // mostly well-formed frames with random content, plus noise and broken frames
  task automatic test_random_stream();
    int unsigned start;
    int unsigned pick;
    start = bytes_sent;
    while (bytes_sent < start + RANDOM_BYTES) begin
      pick = $urandom_range(0, 9);
      if (pick <= 5)
        send_frame(rand_data(), WIN_BYTES, NO_FLIP);
      else if (pick == 6)
        repeat ($urandom_range(1, 30)) send_byte(8'($urandom));
      else if (pick == 7)
        send_frame(rand_data(), WIN_BYTES, $urandom_range(0, WIN_BYTES - 1));
      else if (pick == 8)
        send_frame(rand_data(), $urandom_range(1, WIN_BYTES - 1), NO_FLIP);
      else
        repeat ($urandom_range(1, 30)) send_byte(8'h00);
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    in_byte_i     <= '0;
    hold_requests <= 0;
    foreach (window_q[i]) window_q[i] = '0;
    refill_cnt = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_refill_after_reset();
    test_extreme_words();
    test_back_pressure();
    test_random_stream();

    in_valid_i <= 1'b0;
    while (packets_due.size() != 0) @(posedge clk_i);
    repeat (4 * WPP) @(posedge clk_i);
    if (mismatch_cnt == 0 && packets_due.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
